FILE: rtl/flipdot_row_refresh_driver_top_defines.svh
// assertion macros shared by the flip-dot row refresh driver
`ifndef FLIPDOT_ROW_REFRESH_DRIVER_TOP_DEFINES_SVH
`define FLIPDOT_ROW_REFRESH_DRIVER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FRR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frr assertion failed");

// next-cycle implication, checked outside reset
`define FRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frr assertion failed");

`endif

FILE: rtl/frr_pkg.sv
package frr_pkg;

   // display geometry
   localparam int NUM_ROWS      = 16;
   localparam int COLUMN_COUNT  = 24;
   localparam int BYTES_PER_ROW = (COLUMN_COUNT + 7) / 8;
   localparam int FRAME_BYTES   = NUM_ROWS * BYTES_PER_ROW;
   localparam int SHIFT_BEATS   = (NUM_ROWS > COLUMN_COUNT) ? NUM_ROWS : COLUMN_COUNT;

   // derived widths
   localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int IDX_W = (BYTES_PER_ROW > 1) ? $clog2(BYTES_PER_ROW) : 1;
   localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int K_W   = $clog2(SHIFT_BEATS + 1);

   // result field widths
   localparam int KIND_W    = 2;
   localparam int ROW_OUT_W = 4;

   // beat kinds
   localparam logic [KIND_W-1:0] BEAT_SHIFT  = 2'd0;
   localparam logic [KIND_W-1:0] BEAT_STROBE = 2'd1;
   localparam logic [KIND_W-1:0] BEAT_FLIP0  = 2'd2;
   localparam logic [KIND_W-1:0] BEAT_FLIP1  = 2'd3;

   // one row of bytes, byte 0 holds columns 7..0
   typedef logic [BYTES_PER_ROW-1:0][7:0] row_bytes_type;

   // run request from the frame update logic to the beat sequencer
   typedef struct packed {
      logic             start;
      logic             diff;
      logic [ROW_W-1:0] row;
   } run_cmd_type;

endpackage

FILE: rtl/frr_beat_gen.sv
`include "flipdot_row_refresh_driver_top_defines.svh"

module frr_beat_gen
   import frr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  run_cmd_type          run_cmd,
   input  row_bytes_type        new_bytes,
   input  row_bytes_type        zero_mask,
   input  row_bytes_type        one_mask,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_beat_kind,
   output logic                 rsp_row_data_bit,
   output logic                 rsp_column_data_bit,
   output logic                 rsp_row_clock_pulse,
   output logic                 rsp_column_clock_pulse,
   output logic [ROW_OUT_W-1:0] rsp_current_row,
   output logic                 rsp_last_of_run
);

   // run phases
   localparam logic [2:0] PH_SHIFT_ROW = 3'd0;
   localparam logic [2:0] PH_STROBE0   = 3'd1;
   localparam logic [2:0] PH_FLIP0     = 3'd2;
   localparam logic [2:0] PH_SHIFT_COL = 3'd3;
   localparam logic [2:0] PH_STROBE1   = 3'd4;
   localparam logic [2:0] PH_FLIP1     = 3'd5;

   localparam logic [K_W-1:0] K_SHIFT_LAST = K_W'(SHIFT_BEATS - 1);
   localparam logic [K_W-1:0] K_COL_LAST   = K_W'(COLUMN_COUNT - 1);
   localparam logic [K_W-1:0] K_ROW_LAST   = K_W'(NUM_ROWS - 1);
   localparam logic [K_W-1:0] K_NUM_ROWS   = K_W'(NUM_ROWS);
   localparam logic [K_W-1:0] K_COL_COUNT  = K_W'(COLUMN_COUNT);

   logic [2:0]       phase_ff, phase_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic             busy_ff, busy_in;
   logic             diff_ff;
   logic [ROW_W-1:0] row_ff;

   logic                 valid_ff;
   logic [KIND_W-1:0]    kind_ff;
   logic                 rd_ff, cd_ff, rc_ff, cc_ff, last_ff;
   logic [ROW_OUT_W-1:0] row_out_ff;

   logic                 load;
   logic [KIND_W-1:0]    kind;
   logic                 rd, cd, rc, cc, last;
   logic [K_W-1:0]       col_bit;
   logic [K_W-1:0]       row_tap;
   logic [IDX_W-1:0]     col_byte;
   row_bytes_type        col_src;

   assign load = busy_ff && (!valid_ff || rsp_ready);

   // column bit taken highest first, row select tap for this row
   assign col_bit  = K_COL_LAST - k_ff;
   assign col_byte = IDX_W'(col_bit >> 3);
   assign row_tap  = K_ROW_LAST - K_W'(row_ff);

   // beat contents and next phase
   always_comb begin
      kind     = BEAT_SHIFT;
      rc       = 1'b0;
      cc       = 1'b0;
      last     = 1'b0;
      col_src  = one_mask;
      phase_in = phase_ff;
      k_in     = k_ff;
      busy_in  = busy_ff;
      case (phase_ff)
         PH_SHIFT_ROW: begin
            rc      = (k_ff < K_NUM_ROWS);
            cc      = (k_ff < K_COL_COUNT);
            col_src = diff_ff ? zero_mask : new_bytes;
            if (k_ff == K_SHIFT_LAST) begin
               phase_in = PH_STROBE0;
               k_in     = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         PH_STROBE0: begin
            kind     = BEAT_STROBE;
            phase_in = PH_FLIP0;
         end
         PH_FLIP0: begin
            kind     = BEAT_FLIP0;
            phase_in = diff_ff ? PH_SHIFT_COL : PH_FLIP1;
         end
         PH_SHIFT_COL: begin
            cc = 1'b1;
            if (k_ff == K_COL_LAST) begin
               phase_in = PH_STROBE1;
               k_in     = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         PH_STROBE1: begin
            kind     = BEAT_STROBE;
            phase_in = PH_FLIP1;
         end
         PH_FLIP1: begin
            kind    = BEAT_FLIP1;
            last    = 1'b1;
            busy_in = 1'b0;
         end
         default: begin
            busy_in = 1'b0;
         end
      endcase
   end

   assign rd = rc && (k_ff == row_tap);
   assign cd = cc && col_src[col_byte][col_bit[2:0]];

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= PH_SHIFT_ROW;
         k_ff     <= '0;
      end else if (run_cmd.start) begin
         busy_ff  <= 1'b1;
         phase_ff <= PH_SHIFT_ROW;
         k_ff     <= '0;
      end else if (load) begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
      end
   end

   // run attributes sampled at start
   always_ff @(posedge clock) begin
      if (run_cmd.start) begin
         diff_ff <= run_cmd.diff;
         row_ff  <= run_cmd.row;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind;
         rd_ff      <= rd;
         cd_ff      <= cd;
         rc_ff      <= rc;
         cc_ff      <= cc;
         last_ff    <= last;
         row_out_ff <= ROW_OUT_W'(row_ff);
      end
   end

   assign busy                   = busy_ff;
   assign rsp_valid              = valid_ff;
   assign rsp_beat_kind          = kind_ff;
   assign rsp_row_data_bit       = rd_ff;
   assign rsp_column_data_bit    = cd_ff;
   assign rsp_row_clock_pulse    = rc_ff;
   assign rsp_column_clock_pulse = cc_ff;
   assign rsp_current_row        = row_out_ff;
   assign rsp_last_of_run        = last_ff;

   // checks
   `FRR_ASSERT_IMPL(a_last_is_flip1, clock, reset, valid_ff && last_ff, kind_ff == BEAT_FLIP1)
   `FRR_ASSERT_IMPL(a_start_when_free, clock, reset, run_cmd.start, !busy_ff)
   `FRR_ASSERT_IMPL(a_pulse_only_shift, clock, reset, valid_ff && (kind_ff != BEAT_SHIFT), !rc_ff && !cc_ff && !rd_ff && !cd_ff)
   `FRR_ASSERT_NEXT(a_last_frees_seq, clock, reset, load && (phase_ff == PH_FLIP1) && !run_cmd.start, !busy_ff)

endmodule

FILE: rtl/flipdot_row_refresh_driver_top.sv
// channel  direction  handshake               payload
// req      in         req_valid / req_ready   req_frame_byte, req_frame_start
// rsp      out        rsp_valid / rsp_ready   beat kind, data bits, clocks, row, last
// csr      in         csr_valid / csr_ready   csr_differential_mode
//
// a byte that does not end a row takes a frame store read, then an update
// a row-ending byte adds its run: 27 beats in full mode, 52 in differential mode,
// one beat a cycle from the beat sequencer while rsp is not stalled
// the next byte is taken once the last beat of a run sits in the output register
// reset clears the frame store at once through per-entry valid bits, no sweep
// csr is always ready; the mode is sampled when a row completes
`include "flipdot_row_refresh_driver_top_defines.svh"

module flipdot_row_refresh_driver_top
   import frr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_frame_byte,
   input  logic                 req_frame_start,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [KIND_W-1:0]    rsp_beat_kind,
   output logic                 rsp_row_data_bit,
   output logic                 rsp_column_data_bit,
   output logic                 rsp_row_clock_pulse,
   output logic                 rsp_column_clock_pulse,
   output logic [ROW_OUT_W-1:0] rsp_current_row,
   output logic                 rsp_last_of_run,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_differential_mode
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_UPD  = 1'b1;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BYTES_PER_ROW - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   logic             state_ff, state_in;
   logic             mode_ff;
   logic [POS_W-1:0] pos_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [ROW_W-1:0] row_ff;
   logic             changed_ff;

   // shown frame store and its valid bits
   logic [7:0]             frame_mem [FRAME_BYTES];
   logic [FRAME_BYTES-1:0] frame_vld_ff;
   logic [7:0]             rd_data_ff;
   logic                   rd_vld_ff;

   // transaction being worked on
   logic [POS_W-1:0] addr_ff;
   logic [IDX_W-1:0] idx_q_ff;
   logic [ROW_W-1:0] row_q_ff;
   logic [7:0]       nb_ff;

   row_bytes_type new_bytes_ff, zero_mask_ff, one_mask_ff;

   logic             accept;
   logic             gen_busy;
   logic [POS_W-1:0] addr_in;
   logic [IDX_W-1:0] idx_in;
   logic [ROW_W-1:0] row_in;
   logic [7:0]       old_byte, z_byte, o_byte;
   logic             chg, changed_in, upd;
   run_cmd_type      run_cmd;

   assign req_ready = (state_ff == ST_IDLE) && !gen_busy;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign upd       = (state_ff == ST_UPD);

   // byte position, restarted by frame_start
   assign addr_in = req_frame_start ? '0 : pos_ff;
   assign idx_in  = req_frame_start ? '0 : idx_ff;
   assign row_in  = req_frame_start ? '0 : row_ff;

   // control state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_UPD;
         ST_UPD:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else if (csr_valid) begin
         mode_ff <= csr_differential_mode;
      end
   end

   // position counters advance on each transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         idx_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         pos_ff <= (addr_in == POS_LAST) ? '0 : addr_in + 1'b1;
         if (idx_in == IDX_LAST) begin
            idx_ff <= '0;
            row_ff <= (row_in == ROW_LAST) ? '0 : row_in + 1'b1;
         end else begin
            idx_ff <= idx_in + 1'b1;
            row_ff <= row_in;
         end
      end
   end

   // capture the transaction and read the shown byte
   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff    <= addr_in;
         idx_q_ff   <= idx_in;
         row_q_ff   <= row_in;
         nb_ff      <= req_frame_byte;
         rd_data_ff <= frame_mem[addr_in];
         rd_vld_ff  <= frame_vld_ff[addr_in];
      end
   end

   // masks and change test
   assign old_byte   = rd_vld_ff ? rd_data_ff : 8'h00;
   assign z_byte     = ~(old_byte & ~nb_ff);
   assign o_byte     = ~old_byte & nb_ff;
   assign chg        = (z_byte != 8'hFF) || (o_byte != 8'h00);
   assign changed_in = (idx_q_ff == '0) ? chg : (changed_ff || chg);

   // write back the new byte
   always_ff @(posedge clock) begin
      if (upd) begin
         frame_mem[addr_ff] <= nb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_vld_ff <= '0;
         changed_ff   <= 1'b0;
      end else if (upd) begin
         frame_vld_ff[addr_ff] <= 1'b1;
         changed_ff            <= changed_in;
      end
   end

   // row buffers for the run
   always_ff @(posedge clock) begin
      if (upd) begin
         new_bytes_ff[idx_q_ff] <= nb_ff;
         zero_mask_ff[idx_q_ff] <= z_byte;
         one_mask_ff[idx_q_ff]  <= o_byte;
      end
   end

   // launch a run at the end of a row, in differential mode only if the row changed
   assign run_cmd.start = upd && (idx_q_ff == IDX_LAST) && (!mode_ff || changed_in);
   assign run_cmd.diff  = mode_ff;
   assign run_cmd.row   = row_q_ff;

   frr_beat_gen u_beat_gen (
      .clock                  (clock),
      .reset                  (reset),
      .run_cmd                (run_cmd),
      .new_bytes              (new_bytes_ff),
      .zero_mask              (zero_mask_ff),
      .one_mask               (one_mask_ff),
      .busy                   (gen_busy),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_beat_kind          (rsp_beat_kind),
      .rsp_row_data_bit       (rsp_row_data_bit),
      .rsp_column_data_bit    (rsp_column_data_bit),
      .rsp_row_clock_pulse    (rsp_row_clock_pulse),
      .rsp_column_clock_pulse (rsp_column_clock_pulse),
      .rsp_current_row        (rsp_current_row),
      .rsp_last_of_run        (rsp_last_of_run)
   );

   // checks
   `FRR_ASSERT_NEXT(a_accept_to_upd, clock, reset, accept, state_ff == ST_UPD)
   `FRR_ASSERT_NEXT(a_upd_marks_valid, clock, reset, upd, frame_vld_ff[addr_ff])
   `FRR_ASSERT_IMPL(a_run_on_row_end, clock, reset, run_cmd.start, idx_q_ff == IDX_LAST)

endmodule

FILE: test/tb_flipdot_row_refresh_driver_top.sv
module tb_flipdot_row_refresh_driver_top
   import frr_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // run lengths that can be read straight off the beat sequence
   localparam int RUN_FULL  = SHIFT_BEATS + 3;
   localparam int RUN_SPLIT = SHIFT_BEATS + 2 + COLUMN_COUNT + 2;
   localparam int NOT_TYPED = -1;

   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_ITEMS    = 42;
   localparam int PRESSURE_ITEMS = 20;
   localparam int DIRECTED_ROWS  = 22;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 row_bit;
      logic                 col_bit;
      logic                 row_clk;
      logic                 col_clk;
      logic [ROW_OUT_W-1:0] row;
      logic                 last;
   } refresh_beat_type;

   typedef struct packed {
      logic       mode;
      logic       start;
      logic [7:0] data;
      int         beats;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_frame_byte = 8'h00;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [KIND_W-1:0]    rsp_beat_kind;
   logic                 rsp_row_data_bit;
   logic                 rsp_column_data_bit;
   logic                 rsp_row_clock_pulse;
   logic                 rsp_column_clock_pulse;
   logic [ROW_OUT_W-1:0] rsp_current_row;
   logic                 rsp_last_of_run;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic                 csr_differential_mode = 1'b0;

   // shadow copy of the display state
   logic [7:0]    shown_copy [FRAME_BYTES];
   int unsigned   byte_slot;
   row_bytes_type row_new;
   row_bytes_type row_zero_mask;
   row_bytes_type row_one_mask;
   logic          row_dirty;
   logic          mode_diff;

   refresh_beat_type pending_beats [$];

   int  mismatch_count = 0;
   int  beats_checked  = 0;
   int  bytes_sent     = 0;
   int  mode_writes    = 0;
   int  quiet_cycles   = 0;
   int  tx_idle_pct    = 0;
   int  rx_stall_pct   = 0;
   int  hold_left      = 0;
   bit  hold_trigger   = 1'b0;
   bit  hold_done      = 1'b0;
   bit  keep_row       = 1'b0;

   int tx_pattern [4] = '{0, 66, 0, 8};
   int rx_pattern [4] = '{0, 0, 66, 8};

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // unchanged row after reset gives nothing
      '{1'b1, 1'b1, 8'h00, 0}, '{1'b1, 1'b0, 8'h00, 0}, '{1'b1, 1'b0, 8'h00, 0},
      // all ones and a mixed row, both changed
      '{1'b1, 1'b0, 8'hFF, 0}, '{1'b1, 1'b0, 8'hFF, 0}, '{1'b1, 1'b0, 8'hFF, RUN_SPLIT},
      '{1'b1, 1'b0, 8'h80, 0}, '{1'b1, 1'b0, 8'h01, 0}, '{1'b1, 1'b0, 8'h5A, RUN_SPLIT},
      // partial row dropped by a restart
      '{1'b1, 1'b0, 8'h33, 0}, '{1'b1, 1'b1, 8'hA5, 0}, '{1'b1, 1'b0, 8'h00, 0},
      '{1'b1, 1'b0, 8'h00, NOT_TYPED},
      // full mode rewrites even an unchanged row
      '{1'b0, 1'b1, 8'hFF, 0}, '{1'b0, 1'b0, 8'h00, 0}, '{1'b0, 1'b0, 8'h81, RUN_FULL},
      '{1'b0, 1'b0, 8'hFF, 0}, '{1'b0, 1'b0, 8'hFF, 0}, '{1'b0, 1'b0, 8'hFF, RUN_FULL},
      // back to differential, row unchanged
      '{1'b1, 1'b0, 8'h80, 0}, '{1'b1, 1'b0, 8'h01, 0}, '{1'b1, 1'b0, 8'h5A, 0}
   };

   flipdot_row_refresh_driver_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_frame_byte         (req_frame_byte),
      .req_frame_start        (req_frame_start),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_beat_kind          (rsp_beat_kind),
      .rsp_row_data_bit       (rsp_row_data_bit),
      .rsp_column_data_bit    (rsp_column_data_bit),
      .rsp_row_clock_pulse    (rsp_row_clock_pulse),
      .rsp_column_clock_pulse (rsp_column_clock_pulse),
      .rsp_current_row        (rsp_current_row),
      .rsp_last_of_run        (rsp_last_of_run),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_differential_mode  (csr_differential_mode)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void push_beat(logic [KIND_W-1:0] kind, logic rd, logic cd,
                                     logic rc, logic cc, int unsigned row, logic last);
      refresh_beat_type beat;
      beat = '{kind, rd, cd, rc, cc, row[ROW_OUT_W-1:0], last};
      pending_beats.push_back(beat);
   endfunction

   // shift beats, highest bit first; row register idle when with_row is clear
   function automatic void queue_shift_beats(int unsigned row, bit with_row,
                                             row_bytes_type cmask);
      logic [BYTES_PER_ROW*8-1:0] col_bits;
      int   rlen;
      int   beats;
      logic rc;
      logic cc;
      logic rd;
      logic cd;
      col_bits = cmask;
      rlen = with_row ? NUM_ROWS : 0;
      beats = (rlen > COLUMN_COUNT) ? rlen : COLUMN_COUNT;
      for (int k = 0; k < beats; k++) begin
         rc = (k < rlen);
         cc = (k < COLUMN_COUNT);
         rd = rc ? ((rlen - 1 - k) == int'(row)) : 1'b0;
         cd = cc ? col_bits[COLUMN_COUNT - 1 - k] : 1'b0;
         push_beat(BEAT_SHIFT, rd, cd, rc, cc, row, 1'b0);
      end
   endfunction

   // update the shadow frame with one byte and queue the beats of a finished row
   function automatic int predict_refresh(logic [7:0] nb, logic st);
      int unsigned pos;
      int unsigned idx;
      int unsigned row;
      logic [7:0]  old;
      logic [7:0]  z;
      logic [7:0]  o;
      int          queued;
      queued = pending_beats.size();
      pos = st ? 0 : byte_slot;
      if (pos >= FRAME_BYTES) pos = 0;
      idx = pos % BYTES_PER_ROW;
      row = pos / BYTES_PER_ROW;
      old = shown_copy[pos];
      if (idx == 0) row_dirty = 1'b0;
      z = ~(old & ~nb);
      o = ~old & nb;
      row_new[idx]       = nb;
      row_zero_mask[idx] = z;
      row_one_mask[idx]  = o;
      if (z != 8'hFF || o != 8'h00) row_dirty = 1'b1;
      shown_copy[pos] = nb;
      byte_slot = (pos + 1 >= FRAME_BYTES) ? 0 : pos + 1;
      if (idx == BYTES_PER_ROW - 1) begin
         if (!mode_diff) begin
            queue_shift_beats(row, 1'b1, row_new);
            push_beat(BEAT_STROBE, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b0);
            push_beat(BEAT_FLIP0, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b0);
            push_beat(BEAT_FLIP1, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b1);
         end else if (row_dirty) begin
            queue_shift_beats(row, 1'b1, row_zero_mask);
            push_beat(BEAT_STROBE, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b0);
            push_beat(BEAT_FLIP0, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b0);
            queue_shift_beats(row, 1'b0, row_one_mask);
            push_beat(BEAT_STROBE, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b0);
            push_beat(BEAT_FLIP1, 1'b0, 1'b0, 1'b0, 1'b0, row, 1'b1);
         end
      end
      return pending_beats.size() - queued;
   endfunction

   // four-state compare so an unknown on the outputs is caught
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // send one byte, predicting at the accepting edge
   task automatic send_byte(input logic [7:0] b, input logic st, output int beats);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_frame_byte  <= b;
      req_frame_start <= st;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats = predict_refresh(b, st);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_valid             <= 1'b1;
      csr_differential_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_diff = m;
      mode_writes++;
      csr_valid <= 1'b0;
   endtask

   // mostly whole rows, often unchanged, with restarts mid-row as noise
   task automatic send_random_byte();
      int unsigned pos;
      logic        st;
      logic [7:0]  b;
      int          beats;
      st = 1'b0;
      if (byte_slot == 0) st = 1'($urandom_range(1));
      else if ($urandom_range(49) == 0) st = 1'b1;
      pos = st ? 0 : byte_slot;
      if (pos % BYTES_PER_ROW == 0) keep_row = ($urandom_range(2) == 0);
      if (keep_row) begin
         b = shown_copy[pos];
      end else begin
         case ($urandom_range(7))
            0, 1: b = shown_copy[pos];
            2: b = 8'h00;
            3: b = 8'hFF;
            4: b = shown_copy[pos] ^ (8'h01 << $urandom_range(7));
            default: b = 8'($urandom_range(255));
         endcase
      end
      send_byte(b, st, beats);
   endtask

   // receiver: random stalls plus one long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_trigger && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // check each beat transaction against the oldest expectation
   always @(posedge clock) begin
      refresh_beat_type want;
      logic             progress;
      progress = (req_valid && req_ready) || (rsp_valid && rsp_ready)
                 || (csr_valid && csr_ready);
      quiet_cycles <= progress ? 0 : quiet_cycles + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            $error("beat with no expectation: kind %0d row %0d", rsp_beat_kind,
                   rsp_current_row);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            compare_field("beat_kind", want.kind, rsp_beat_kind);
            compare_field("row_data_bit", want.row_bit, rsp_row_data_bit);
            compare_field("column_data_bit", want.col_bit, rsp_column_data_bit);
            compare_field("row_clock_pulse", want.row_clk, rsp_row_clock_pulse);
            compare_field("column_clock_pulse", want.col_clk, rsp_column_clock_pulse);
            compare_field("current_row", want.row, rsp_current_row);
            compare_field("last_of_run", want.last, rsp_last_of_run);
            beats_checked++;
         end
      end
   end

   // watchdog on cycles without any transaction
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      int beats;
      directed_row_type entry;
      for (int i = 0; i < FRAME_BYTES; i++) shown_copy[i] = 8'h00;
      byte_slot     = 0;
      row_new       = '0;
      row_zero_mask = '0;
      row_one_mask  = '0;
      row_dirty     = 1'b0;
      mode_diff     = 1'b1;

      // reset
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         entry = directed_rows[i];
         if (entry.mode != mode_diff) begin
            wait_idle();
            write_mode(entry.mode);
         end
         send_byte(entry.data, entry.start, beats);
         if (entry.beats != NOT_TYPED && entry.beats != beats) begin
            $error("run_beats expected %0d actual %0d", entry.beats, beats);
            mismatch_count++;
         end
      end

      // random phases over idle mixes, both modes each
      for (int p = 0; p < 8; p++) begin
         wait_idle();
         write_mode((p % 2) == 0);
         tx_idle_pct  = tx_pattern[p / 2];
         rx_stall_pct = rx_pattern[p / 2];
         repeat (PHASE_ITEMS) send_random_byte();
      end

      // long receiver hold while bytes keep coming
      wait_idle();
      write_mode(1'b1);
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_trigger = 1'b1;
      repeat (PRESSURE_ITEMS) send_random_byte();

      // drain
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      $display("%0d frame bytes, %0d beats checked, %0d mode writes", bytes_sent,
               beats_checked, mode_writes);
      $display("covered idle mixes, restarts, frame wrap and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
